// File: design/rqbd_pkg.sv
// rqbd_pkg: shared codes, command and status types for the ring queue batch dequeue block
// no dependencies

package rqbd_pkg;

   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int OCC_W      = 8;
   localparam int LIMIT_W    = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
   localparam logic [OP_W-1:0] OP_BATCH = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [LIMIT_W-1:0] BATCH_CAP   = 6'd32;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

   // word index of the batch limit register
   localparam logic REG_BATCH_LIMIT = 1'b0;

   typedef enum logic [1:0] {
      SRC_ENQ,
      SRC_EMPTY,
      SRC_POP
   } rsp_src_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_POP  = 2'b10
   } state_type;

   typedef struct packed {
      logic        wr_en;
      logic        rd_en;
      logic        batch_load;
      logic        batch_single;
      logic        rsp_load;
      rsp_src_type rsp_src;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic out_free;
      logic last_pop;
   } stat_type;

endpackage

// File: design/rqbd_csr.sv
// rqbd_csr: register port holding the batch limit
// depends on rqbd_pkg

module rqbd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rqbd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rqbd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rqbd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [rqbd_pkg::LIMIT_W-1:0]     batch_limit
);
   import rqbd_pkg::*;

   logic [LIMIT_W-1:0] batch_limit_ff;
   logic [LIMIT_W-1:0] batch_limit_in;
   logic               reg_hit;

   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1] == REG_BATCH_LIMIT);
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_hit ? CSR_DATA_W'(batch_limit_ff) : '0;
   assign batch_limit = batch_limit_ff;

   always_comb begin
      batch_limit_in = batch_limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         batch_limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_limit_ff <= LIMIT_RESET;
      end else begin
         batch_limit_ff <= batch_limit_in;
      end
   end

endmodule

// File: design/rqbd_ctrl.sv
// rqbd_ctrl: controller state machine sequencing enqueue, dequeue and batch transfers
// depends on rqbd_pkg

module rqbd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rqbd_pkg::OP_W-1:0]  req_op,
   input  rqbd_pkg::stat_type         stat,
   output rqbd_pkg::cmd_type          cmd
);
   import rqbd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.rsp_src = SRC_ENQ;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               case (req_op)
                  OP_ENQ: begin
                     cmd.wr_en    = !stat.full;
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_src  = SRC_ENQ;
                  end
                  OP_DEQ, OP_BATCH: begin
                     if (stat.empty) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_src  = SRC_EMPTY;
                     end else begin
                        cmd.rd_en        = 1'b1;
                        cmd.batch_load   = 1'b1;
                        cmd.batch_single = (req_op == OP_DEQ);
                        state_in         = S_POP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_POP: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_src  = SRC_POP;
               if (stat.last_pop) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/rqbd_datapath.sv
// rqbd_datapath: slot memory, pointers, occupancy, batch counter and result register
// depends on rqbd_pkg

module rqbd_datapath #(
   parameter int DEPTH       = 256,
   parameter int ENTRY_WIDTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rqbd_pkg::cmd_type             cmd,
   output rqbd_pkg::stat_type            stat,
   input  logic [ENTRY_WIDTH-1:0]        req_entry_in,
   input  logic [rqbd_pkg::LIMIT_W-1:0]  batch_limit,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [rqbd_pkg::STATUS_W-1:0] rsp_status,
   output logic [ENTRY_WIDTH-1:0]        rsp_entry_out,
   output logic                          rsp_last,
   output logic [rqbd_pkg::OCC_W-1:0]    rsp_occupancy
);
   import rqbd_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CMP_W = (PTR_W > LIMIT_W) ? PTR_W : LIMIT_W;

   logic [ENTRY_WIDTH-1:0] mem [DEPTH];

   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]       count_ff, count_in;
   logic [LIMIT_W-1:0]     remain_ff, remain_in;
   logic [ENTRY_WIDTH-1:0] rd_data_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [ENTRY_WIDTH-1:0] rsp_entry_ff, rsp_entry_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [OCC_W-1:0]       rsp_occ_ff, rsp_occ_in;

   logic [PTR_W-1:0]       wr_ptr_inc;
   logic [LIMIT_W-1:0]     lim_eff;
   logic [CMP_W-1:0]       cnt_x, lim_x;
   logic [LIMIT_W-1:0]     batch_n;

   assign wr_ptr_inc    = wr_ptr_ff + PTR_W'(1);
   assign stat.full     = (wr_ptr_inc == rd_ptr_ff);
   assign stat.empty    = (count_ff == '0);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.last_pop = (remain_ff == LIMIT_W'(1));

   // batch size: limit clamped to 1..32, then to the occupancy
   always_comb begin
      if (batch_limit == '0) begin
         lim_eff = LIMIT_W'(1);
      end else if (batch_limit > BATCH_CAP) begin
         lim_eff = BATCH_CAP;
      end else begin
         lim_eff = batch_limit;
      end
      cnt_x   = CMP_W'(count_ff);
      lim_x   = CMP_W'(lim_eff);
      batch_n = (cnt_x < lim_x) ? cnt_x[LIMIT_W-1:0] : lim_x[LIMIT_W-1:0];
   end

   always_comb begin
      wr_ptr_in = cmd.wr_en ? wr_ptr_inc : wr_ptr_ff;
      rd_ptr_in = cmd.rd_en ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      if (cmd.wr_en) begin
         count_in = count_ff + PTR_W'(1);
      end else if (cmd.rd_en) begin
         count_in = count_ff - PTR_W'(1);
      end else begin
         count_in = count_ff;
      end
      if (cmd.batch_load) begin
         remain_in = cmd.batch_single ? LIMIT_W'(1) : batch_n;
      end else if (cmd.rsp_load && (cmd.rsp_src == SRC_POP)) begin
         remain_in = remain_ff - LIMIT_W'(1);
      end else begin
         remain_in = remain_ff;
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (cmd.rsp_load) begin
         case (cmd.rsp_src)
            SRC_ENQ: begin
               rsp_status_in = stat.full ? ST_FULL : ST_OK;
               rsp_entry_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_occ_in    = OCC_W'(count_in);
            end
            SRC_EMPTY: begin
               rsp_status_in = ST_EMPTY;
               rsp_entry_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_occ_in    = '0;
            end
            SRC_POP: begin
               rsp_status_in = ST_OK;
               rsp_entry_in  = rd_data_ff;
               rsp_last_in   = stat.last_pop;
               rsp_occ_in    = OCC_W'(count_ff);
            end
            default: ;
         endcase
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_ptr_ff] <= req_entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_entry_out = rsp_entry_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

// File: design/ring_queue_batch_dequeue.sv
// ring_queue_batch_dequeue: top level of the descriptor ring queue with batch dequeue
// depends on rqbd_pkg, rqbd_csr, rqbd_ctrl, rqbd_datapath
//
//   channel  | ports               | handshake     | carries
//   ---------+---------------------+---------------+------------------------------------
//   request  | req_*               | valid / ready | op, entry_in
//   response | rsp_*               | valid / ready | status, entry_out, last, occupancy
//   register | csr_*               | apb, pready=1 | batch_limit at byte address 0
//
// enqueue and empty dequeue: taken while the output is free, result registered next cycle
// dequeue: the slot memory read is registered before the result is loaded
// batch of n entries: one result per cycle after the first read, while the output is free
// a stalled rsp_ready holds the output register and the sequencer; no request taken meanwhile
// synchronous reset clears pointers, occupancy and control; the slot memory is not cleared

module ring_queue_batch_dequeue #(
   parameter int DEPTH       = 256,
   parameter int ENTRY_WIDTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rqbd_pkg::OP_W-1:0]        req_op,
   input  logic [ENTRY_WIDTH-1:0]           req_entry_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rqbd_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ENTRY_WIDTH-1:0]           rsp_entry_out,
   output logic                             rsp_last,
   output logic [rqbd_pkg::OCC_W-1:0]       rsp_occupancy,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rqbd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rqbd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rqbd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import rqbd_pkg::*;

   cmd_type            cmd;
   stat_type           stat;
   logic [LIMIT_W-1:0] batch_limit;

   rqbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .batch_limit (batch_limit)
   );

   rqbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .stat      (stat),
      .cmd       (cmd)
   );

   rqbd_datapath #(
      .DEPTH       (DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_entry_in  (req_entry_in),
      .batch_limit   (batch_limit),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_entry_out (rsp_entry_out),
      .rsp_last      (rsp_last),
      .rsp_occupancy (rsp_occupancy)
   );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for ring_queue_batch_dequeue, directed table then random phases
// depends on rqbd_pkg and the ring_queue_batch_dequeue rtl

module tb;
   import rqbd_pkg::*;

   localparam int DEPTH       = 256;
   localparam int ENTRY_W     = 64;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int STALL_LIMIT = 1000;
   localparam int QUIET_WAIT  = 8;
   localparam int SHOWN_ERRS  = 10;

   localparam logic [OP_W-1:0]       OP_UNUSED     = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR    = {REG_BATCH_LIMIT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_BATCH_LIMIT, 2'b00};

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  entry;
      logic                last;
      logic [OCC_W-1:0]    occ;
   } reply_type;

   typedef struct packed {
      logic               is_cfg;
      logic [OP_W-1:0]    op;
      logic [ENTRY_W-1:0] data;
      logic               typed;
      reply_type          want;
   } plan_row_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_MOSTLY,
      RDY_PERIODIC
   } ready_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op;
   logic [ENTRY_W-1:0]    req_entry_in;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ENTRY_W-1:0]    rsp_entry_out;
   logic                  rsp_last;
   logic [OCC_W-1:0]      rsp_occupancy;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ring_queue_batch_dequeue #(
      .DEPTH(DEPTH),
      .ENTRY_WIDTH(ENTRY_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_entry_in(req_entry_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_entry_out(rsp_entry_out),
      .rsp_last(rsp_last),
      .rsp_occupancy(rsp_occupancy),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // queue mirror
   logic [ENTRY_W-1:0] mirror_slot [DEPTH];
   logic [PTR_W-1:0]   mirror_wr    = '0;
   logic [PTR_W-1:0]   mirror_rd    = '0;
   logic [PTR_W-1:0]   mirror_count = '0;
   logic [LIMIT_W-1:0] mirror_limit = LIMIT_RESET;

   reply_type      due_results [$];
   plan_row_type   plan [$];
   logic           typed_now = 1'b0;
   reply_type      want_now  = '0;
   int             errors       = 0;
   int             stall_cycles = 0;
   int             burst_left   = 0;
   ready_mode_type ready_mode   = RDY_ALWAYS;
   int             ready_tick   = 0;
   int             ready_phase  = 0;

   function automatic reply_type reply(input logic [STATUS_W-1:0] status,
                                       input logic [ENTRY_W-1:0] entry,
                                       input logic last, input logic [OCC_W-1:0] occ);
      reply_type r;
      r.status = status;
      r.entry  = entry;
      r.last   = last;
      r.occ    = occ;
      return r;
   endfunction

   function automatic plan_row_type typed_row(input logic [OP_W-1:0] op,
                                              input logic [ENTRY_W-1:0] data,
                                              input reply_type want);
      plan_row_type p;
      p.is_cfg = 1'b0;
      p.op     = op;
      p.data   = data;
      p.typed  = 1'b1;
      p.want   = want;
      return p;
   endfunction

   function automatic plan_row_type step_row(input logic [OP_W-1:0] op,
                                             input logic [ENTRY_W-1:0] data);
      plan_row_type p;
      p       = typed_row(op, data, '0);
      p.typed = 1'b0;
      return p;
   endfunction

   function automatic plan_row_type cfg_row(input logic [CSR_DATA_W-1:0] value);
      plan_row_type p;
      p        = step_row(OP_UNUSED, ENTRY_W'(value));
      p.is_cfg = 1'b1;
      return p;
   endfunction

   function automatic logic [ENTRY_W-1:0] rand_entry();
      logic [ENTRY_W-1:0] v;
      case ($urandom_range(0, 15))
         0: v = '1;
         1: v = '0;
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   task automatic apply_queue_op(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] data,
                                 input logic typed, input reply_type want);
      logic [PTR_W-1:0] next_wr;
      int               lim;
      int               n;
      next_wr = mirror_wr + 1'b1;
      lim     = int'(mirror_limit);
      if (lim == 0) lim = 1;
      if (lim > int'(BATCH_CAP)) lim = int'(BATCH_CAP);
      case (op)
         OP_ENQ: begin
            if (next_wr == mirror_rd) begin
               due_results.push_back(reply(ST_FULL, '0, 1'b1, mirror_count));
            end else begin
               mirror_slot[mirror_wr] = data;
               mirror_wr    = next_wr;
               mirror_count = mirror_count + 1'b1;
               due_results.push_back(reply(ST_OK, '0, 1'b1, mirror_count));
            end
         end
         OP_DEQ, OP_BATCH: begin
            if (mirror_count == '0) begin
               due_results.push_back(reply(ST_EMPTY, '0, 1'b1, '0));
            end else begin
               n = (op == OP_DEQ) ? 1 :
                   ((int'(mirror_count) < lim) ? int'(mirror_count) : lim);
               for (int i = 0; i < n; i++) begin
                  mirror_count = mirror_count - 1'b1;
                  due_results.push_back(reply(ST_OK, mirror_slot[mirror_rd], i == n - 1,
                                              mirror_count));
                  mirror_rd = mirror_rd + 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (typed && op != OP_UNUSED) due_results[due_results.size() - 1] = want;
   endtask

   // transfers on both channels, prediction and checking
   always @(posedge clock) begin
      reply_type got;
      reply_type exp;
      logic      moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            got   = reply(rsp_status, rsp_entry_out, rsp_last, rsp_occupancy);
            if (due_results.size() == 0) begin
               errors++;
               if (errors <= SHOWN_ERRS)
                  $display("unexpected result: status %0d entry %h last %0d occupancy %0d",
                           got.status, got.entry, got.last, got.occ);
            end else begin
               exp = due_results.pop_front();
               if (got !== exp) begin
                  errors++;
                  if (errors <= SHOWN_ERRS)
                     $display({"mismatch (exp/got): status %0d/%0d entry %h/%h",
                               " last %0d/%0d occupancy %0d/%0d"},
                              exp.status, got.status, exp.entry, got.entry,
                              exp.last, got.last, exp.occ, got.occ);
               end
            end
         end
         if (req_valid && req_ready) begin
            moved = 1'b1;
            apply_queue_op(req_op, req_entry_in, typed_now, want_now);
         end
         if (csr_psel && csr_penable && csr_pready) moved = 1'b1;
         stall_cycles = moved ? 0 : stall_cycles + 1;
      end
   end

   always @(negedge clock) begin
      if (ready_tick == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_tick = $urandom_range(20, 80);
      end
      ready_tick--;
      ready_phase++;
      case (ready_mode)
         RDY_ALWAYS: rsp_ready <= 1'b1;
         RDY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RDY_MOSTLY: rsp_ready <= ($urandom_range(0, 4) != 0);
         default:    rsp_ready <= (ready_phase % 3 == 0);
      endcase
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] data,
                            input logic typed, input reply_type want);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_op       <= op;
      req_entry_in <= data;
      typed_now    <= typed;
      want_now     <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic quiesce();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   // write to the given address, then read back the limit register
   task automatic csr_program(input logic [CSR_ADDR_W-1:0] addr,
                              input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == LIMIT_ADDR) mirror_limit = value[LIMIT_W-1:0];
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= LIMIT_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd !== CSR_DATA_W'(mirror_limit)) begin
         errors++;
         if (errors <= SHOWN_ERRS)
            $display("batch limit readback mismatch: expected %0d got %0d", mirror_limit, rd);
      end
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] limit_word, input int items,
                            input int pct_enq, input int pct_deq, input int pct_batch);
      int              done;
      int              r;
      logic [OP_W-1:0] op;
      quiesce();
      csr_program(LIMIT_ADDR, limit_word);
      done = 0;
      while (done < items) begin
         r = $urandom_range(0, 99);
         if (r < pct_enq) op = OP_ENQ;
         else if (r < pct_enq + pct_deq) op = OP_DEQ;
         else if (r < pct_enq + pct_deq + pct_batch) op = OP_BATCH;
         else op = OP_UNUSED;
         send_item(op, rand_entry(), 1'b0, '0);
         if (op != OP_UNUSED) done++;
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_ENQ;
      req_entry_in = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = LIMIT_ADDR;
      csr_pwdata   = '0;

      plan.push_back(typed_row(OP_DEQ, '0, reply(ST_EMPTY, '0, 1'b1, 8'd0)));
      plan.push_back(typed_row(OP_BATCH, '0, reply(ST_EMPTY, '0, 1'b1, 8'd0)));
      plan.push_back(step_row(OP_UNUSED, '1));
      plan.push_back(typed_row(OP_ENQ, '1, reply(ST_OK, '0, 1'b1, 8'd1)));
      plan.push_back(typed_row(OP_ENQ, '0, reply(ST_OK, '0, 1'b1, 8'd2)));
      plan.push_back(typed_row(OP_DEQ, '0, reply(ST_OK, '1, 1'b1, 8'd1)));
      plan.push_back(typed_row(OP_DEQ, '1, reply(ST_OK, '0, 1'b1, 8'd0)));
      plan.push_back(typed_row(OP_DEQ, '0, reply(ST_EMPTY, '0, 1'b1, 8'd0)));
      plan.push_back(typed_row(OP_ENQ, 64'haaaa_aaaa_aaaa_aaaa, reply(ST_OK, '0, 1'b1, 8'd1)));
      plan.push_back(typed_row(OP_ENQ, 64'h5555_5555_5555_5555, reply(ST_OK, '0, 1'b1, 8'd2)));
      plan.push_back(typed_row(OP_ENQ, 64'h0123_4567_89ab_cdef, reply(ST_OK, '0, 1'b1, 8'd3)));
      plan.push_back(typed_row(OP_ENQ, 64'h8000_0000_0000_0001, reply(ST_OK, '0, 1'b1, 8'd4)));
      plan.push_back(typed_row(OP_ENQ, 64'hfedc_ba98_7654_3210, reply(ST_OK, '0, 1'b1, 8'd5)));
      plan.push_back(step_row(OP_BATCH, '0));
      plan.push_back(step_row(OP_UNUSED, '0));
      plan.push_back(cfg_row(32'd0));
      plan.push_back(typed_row(OP_ENQ, 64'hc3c3_c3c3_c3c3_c3c3, reply(ST_OK, '0, 1'b1, 8'd1)));
      plan.push_back(typed_row(OP_ENQ, 64'h3c3c_3c3c_3c3c_3c3c, reply(ST_OK, '0, 1'b1, 8'd2)));
      plan.push_back(step_row(OP_BATCH, '0));
      plan.push_back(step_row(OP_UNUSED, 64'h0f0f_0f0f_0f0f_0f0f));
      plan.push_back(step_row(OP_BATCH, '1));
      plan.push_back(typed_row(OP_BATCH, '0, reply(ST_EMPTY, '0, 1'b1, 8'd0)));
      plan.push_back(cfg_row(32'hffff_ffff));
      plan.push_back(typed_row(OP_ENQ, 64'hf0f0_f0f0_f0f0_f0f0, reply(ST_OK, '0, 1'b1, 8'd1)));
      plan.push_back(step_row(OP_BATCH, '0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            quiesce();
            csr_program(LIMIT_ADDR, plan[i].data[CSR_DATA_W-1:0]);
         end else begin
            send_item(plan[i].op, plan[i].data, plan[i].typed, plan[i].want);
         end
      end

      // a write outside the register map leaves the limit alone
      quiesce();
      csr_program(UNMAPPED_ADDR, $urandom);

      run_phase({26'($urandom_range(0, 32'h03ff_ffff)), 6'd1}, 40, 50, 20, 25);
      run_phase(32'h0000_003f, 300, 94, 5, 0);
      run_phase({26'($urandom_range(0, 32'h03ff_ffff)), 6'd32}, 35, 15, 25, 55);
      run_phase($urandom, 45, 45, 25, 25);

      quiesce();
      if (errors == 0 && due_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
design/rqbd_pkg.sv
design/rqbd_csr.sv
design/rqbd_ctrl.sv
design/rqbd_datapath.sv
design/ring_queue_batch_dequeue.sv
tb/sv/tb.sv
